>>> rtl/core/cylinder_closest_surface_point_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cylinder closest point block
// Short forms for implication checks on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef CYLINDER_CLOSEST_SURFACE_POINT_MACROS_SVH
`define CYLINDER_CLOSEST_SURFACE_POINT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CCSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too
`define CCSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ccsp_pkg.sv
// ---------------------------------------------------------------------------
// ccsp_pkg
// Widths and register indexes shared by the cylinder closest point block.
// ---------------------------------------------------------------------------
package ccsp_pkg;

  localparam int COORD_W = 32;             // Q16.16 coordinate
  localparam int LEN_W   = 31;             // radius and half length
  localparam int EPS_W   = 16;             // on-axis threshold
  localparam int SQ_W    = 2 * COORD_W;    // sum of squares
  localparam int ROOT_W  = SQ_W / 2;       // radial distance
  localparam int NUM_W   = COORD_W + LEN_W; // scaled numerator
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_HALFLEN = 2'd1,
    CFG_EPSILON = 2'd2
  } cfg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROOT_W-1:0]         root_t;

  // Carried alongside the divider: probe and radial distance
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    root_t  r;
  } div_side_t;

endpackage

>>> rtl/core/ccsp_if.sv
// ---------------------------------------------------------------------------
// ccsp channel interfaces
// Valid/ready channels for probe requests, surface points and register writes.
// ---------------------------------------------------------------------------
interface ccsp_probe_if;
  logic                 valid;
  logic                 ready;
  ccsp_pkg::coord_t     probe_x;
  ccsp_pkg::coord_t     probe_y;
  ccsp_pkg::coord_t     probe_z;
  modport source (output valid, probe_x, probe_y, probe_z, input ready);
  modport sink   (input valid, probe_x, probe_y, probe_z, output ready);
endinterface

interface ccsp_near_if;
  logic                 valid;
  logic                 ready;
  ccsp_pkg::coord_t     near_x;
  ccsp_pkg::coord_t     near_y;
  ccsp_pkg::coord_t     near_z;
  modport source (output valid, near_x, near_y, near_z, input ready);
  modport sink   (input valid, near_x, near_y, near_z, output ready);
endinterface

interface ccsp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ccsp_pkg::CFG_IDX_W-1:0]      index;
  logic [ccsp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ccsp_isqrt.sv
// ---------------------------------------------------------------------------
// ccsp_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module ccsp_isqrt #(
  parameter int SIDE_W = 96
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [ccsp_pkg::SQ_W-1:0]    in_val,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_vld,
  output logic [ccsp_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]            out_side
);
  import ccsp_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic              vld_r  [1:ROOT_W];
  logic [SQ_W-1:0]   val_r  [1:ROOT_W];
  logic [REM_W-1:0]  rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  logic [SIDE_W-1:0] side_r [1:ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    logic              cur_vld;
    logic [SQ_W-1:0]   cur_val;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [SIDE_W-1:0] cur_side;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  tst;

    if (s == 0) begin : g_src
      assign cur_vld  = in_vld;
      assign cur_val  = in_val;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_src
      assign cur_vld  = vld_r[s];
      assign cur_val  = val_r[s];
      assign cur_rem  = rem_r[s];
      assign cur_root = root_r[s];
      assign cur_side = side_r[s];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign sh  = {cur_rem[REM_W-3:0], cur_val[SQ_W-1-2*s -: 2]};
    assign tst = {1'b0, cur_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s+1]  <= cur_val;
        side_r[s+1] <= cur_side;
        if (sh >= tst) begin
          rem_r[s+1]  <= sh - tst;
          root_r[s+1] <= {cur_root[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[s+1]  <= sh;
          root_r[s+1] <= {cur_root[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_side = side_r[ROOT_W];

endmodule

>>> rtl/core/ccsp_div.sv
// ---------------------------------------------------------------------------
// ccsp_div
// Two-lane pipelined restoring divider with a shared divisor.
// ---------------------------------------------------------------------------
module ccsp_div #(
  parameter int SIDE_W = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [1:0][ccsp_pkg::NUM_W-1:0]   in_num,
  input  logic [ccsp_pkg::ROOT_W-1:0]       in_den,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_vld,
  output logic [1:0][ccsp_pkg::ROOT_W-1:0]  out_quot,
  output logic [SIDE_W-1:0]                 out_side
);
  import ccsp_pkg::*;

  // quotient stays below 2^ROOT_W, so the top bits start as the remainder
  localparam int Q_W = ROOT_W;

  logic                        vld_r  [1:Q_W];
  logic [1:0][NUM_W-1:0]       num_r  [1:Q_W];
  logic [ROOT_W-1:0]           den_r  [1:Q_W];
  logic [1:0][ROOT_W-1:0]      rem_r  [1:Q_W];
  logic [1:0][Q_W-1:0]         quot_r [1:Q_W];
  logic [SIDE_W-1:0]           side_r [1:Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_st
    logic                   cur_vld;
    logic [1:0][NUM_W-1:0]  cur_num;
    logic [ROOT_W-1:0]      cur_den;
    logic [1:0][ROOT_W-1:0] cur_rem;
    logic [1:0][Q_W-1:0]    cur_quot;
    logic [SIDE_W-1:0]      cur_side;

    if (s == 0) begin : g_src
      assign cur_vld  = in_vld;
      assign cur_num  = in_num;
      assign cur_den  = in_den;
      assign cur_rem  = {{1'b0, in_num[1][NUM_W-1:Q_W]}, {1'b0, in_num[0][NUM_W-1:Q_W]}};
      assign cur_quot = '0;
      assign cur_side = in_side;
    end else begin : g_src
      assign cur_vld  = vld_r[s];
      assign cur_num  = num_r[s];
      assign cur_den  = den_r[s];
      assign cur_rem  = rem_r[s];
      assign cur_quot = quot_r[s];
      assign cur_side = side_r[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s+1]  <= cur_num;
        den_r[s+1]  <= cur_den;
        side_r[s+1] <= cur_side;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [ROOT_W:0] sh;
      // shift in the next dividend bit and subtract where it fits
      assign sh = {cur_rem[l], cur_num[l][Q_W-1-s]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh >= {1'b0, cur_den}) begin
            rem_r[s+1][l]  <= ROOT_W'(sh - {1'b0, cur_den});
            quot_r[s+1][l] <= {cur_quot[l][Q_W-2:0], 1'b1};
          end else begin
            rem_r[s+1][l]  <= sh[ROOT_W-1:0];
            quot_r[s+1][l] <= {cur_quot[l][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[Q_W];
  assign out_quot = quot_r[Q_W];
  assign out_side = side_r[Q_W];

endmodule

>>> rtl/core/cylinder_closest_surface_point.sv
// ---------------------------------------------------------------------------
// cylinder_closest_surface_point
// Nearest surface point of a closed x-axis cylinder, Q16.16 pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one probe request (probe_x, probe_y, probe_z, signed
//   Q16.16); out_ch returns the nearest point on the closed cylinder
//   surface (near_x, near_y, near_z) in the same order.
//   cfg_ch writes cyl_radius (index 0), half_length (1) and axis_epsilon
//   (2); it is always ready and should only be written while idle.
//   The pipeline has one squaring stage, 32 square root stages (one
//   root bit each), one scaling multiply, 32 divider stages (one quotient
//   bit each) and the output register.
//   Throughput is one request per cycle while out_ch is not stalled;
//   the 32-step root and divider pipelines set the depth.
//   Reset clears all valid bits and loads radius 1.0, half length 1.0 and
//   epsilon of one LSB.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ch.ready drops; bubbles in flight are kept, nothing is
//   lost or repeated.
// ---------------------------------------------------------------------------
module cylinder_closest_surface_point #(
  parameter int DIMS = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  ccsp_probe_if.sink   in_ch,
  ccsp_near_if.source  out_ch,
  ccsp_cfg_if.sink     cfg_ch
);
  import ccsp_pkg::*;
  `include "cylinder_closest_surface_point_macros.svh"

  localparam int ISQ_SIDE_W = 3 * COORD_W;
  localparam int DIV_SIDE_W = $bits(div_side_t);

  logic [LEN_W-1:0] cyl_radius_r, half_length_r;
  logic [EPS_W-1:0] axis_epsilon_r;
  logic             en;

  // register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_radius_r   <= LEN_W'(65536);
      half_length_r  <= LEN_W'(65536);
      axis_epsilon_r <= EPS_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_RADIUS:  cyl_radius_r   <= cfg_ch.data[LEN_W-1:0];
        CFG_HALFLEN: half_length_r  <= cfg_ch.data[LEN_W-1:0];
        CFG_EPSILON: axis_epsilon_r <= cfg_ch.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  coord_t near_x_r, near_y_r, near_z_r;

  // advance everything unless a result is held back
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: magnitudes and squares
  coord_t a_z_in;
  logic [COORD_W-1:0] a_my, a_mz;
  logic               a_vld_r;
  coord_t             a_x_r, a_y_r, a_z_r;
  logic [SQ_W-1:0]    ysq_r, zsq_r;

  assign a_z_in = (DIMS < 3) ? '0 : in_ch.probe_z;
  assign a_my   = in_ch.probe_y[COORD_W-1] ? -in_ch.probe_y : in_ch.probe_y;
  assign a_mz   = a_z_in[COORD_W-1] ? -a_z_in : a_z_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r <= in_ch.probe_x;
      a_y_r <= in_ch.probe_y;
      a_z_r <= a_z_in;
      ysq_r <= a_my * a_my;
      zsq_r <= a_mz * a_mz;
    end
  end

  // square root of y^2 + z^2
  logic                  s_vld;
  root_t                 s_root;
  logic [ISQ_SIDE_W-1:0] s_side;

  ccsp_isqrt #(.SIDE_W(ISQ_SIDE_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (a_vld_r),
    .in_val   (ysq_r + zsq_r),
    .in_side  ({a_x_r, a_y_r, a_z_r}),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_side (s_side)
  );

  // stage M: scale magnitudes by the radius, add half r for rounding
  coord_t             s_y, s_z;
  logic [COORD_W-1:0] s_my, s_mz;
  logic               m_vld_r;
  logic [1:0][NUM_W-1:0] m_num_r;
  div_side_t          m_side_r;

  assign s_y  = s_side[2*COORD_W-1:COORD_W];
  assign s_z  = s_side[COORD_W-1:0];
  assign s_my = s_y[COORD_W-1] ? -s_y : s_y;
  assign s_mz = s_z[COORD_W-1] ? -s_z : s_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num_r[1] <= s_my * cyl_radius_r + NUM_W'(s_root >> 1);
      m_num_r[0] <= s_mz * cyl_radius_r + NUM_W'(s_root >> 1);
      m_side_r   <= '{x: s_side[3*COORD_W-1:2*COORD_W], y: s_y, z: s_z, r: s_root};
    end
  end

  // divide by the radial distance
  logic                   d_vld;
  logic [1:0][ROOT_W-1:0] d_quot;
  div_side_t              d_side;
  logic [DIV_SIDE_W-1:0]  d_side_bits;

  ccsp_div #(.SIDE_W(DIV_SIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m_vld_r),
    .in_num   (m_num_r),
    .in_den   (m_side_r.r),
    .in_side  (m_side_r),
    .out_vld  (d_vld),
    .out_quot (d_quot),
    .out_side (d_side_bits)
  );
  assign d_side = div_side_t'(d_side_bits);

  // region select
  logic [COORD_W-1:0]        mag_x;
  logic signed [COORD_W+1:0] dh, dr;
  logic                      off_axis, axial_out, keep_radial;
  coord_t                    cap_x, my, mz, ky, kz, ox, oy, oz;

  always_comb begin
    mag_x    = d_side.x[COORD_W-1] ? -d_side.x : d_side.x;
    dh       = $signed({2'b00, mag_x}) - $signed({3'b000, half_length_r});
    dr       = $signed({2'b00, d_side.r}) - $signed({3'b000, cyl_radius_r});
    off_axis = d_side.r > {{(ROOT_W-EPS_W){1'b0}}, axis_epsilon_r};
    cap_x    = d_side.x[COORD_W-1] ? -coord_t'({1'b0, half_length_r})
                                   : coord_t'({1'b0, half_length_r});
    if (off_axis) begin
      my = d_side.y[COORD_W-1] ? -d_quot[1] : d_quot[1];
      mz = d_side.z[COORD_W-1] ? -d_quot[0] : d_quot[0];
      ky = d_side.y;
      kz = d_side.z;
    end else begin
      my = coord_t'({1'b0, cyl_radius_r});
      mz = '0;
      ky = '0;
      kz = '0;
    end
    axial_out   = dh > 0;
    keep_radial = (dr <= 0) && (axial_out || (dr < dh));
    ox = (axial_out || (dr <= 0 && dr < dh)) ? cap_x : d_side.x;
    oy = keep_radial ? ky : my;
    oz = (DIMS < 3) ? '0 : (keep_radial ? kz : mz);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_x_r <= ox;
      near_y_r <= oy;
      near_z_r <= oz;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.near_x = near_x_r;
  assign out_ch.near_y = near_y_r;
  assign out_ch.near_z = near_z_r;

  `CCSP_ASSERT_NEXT_ALWAYS(a_reset_clears, !rst_n, !out_vld_r, "output valid after reset")
  `CCSP_ASSERT_NEXT(a_div_to_out, en && d_vld, out_vld_r, "divider result dropped")
  `CCSP_ASSERT_NEXT(a_stall_holds, !en, out_vld_r, "held result lost during stall")
  `CCSP_ASSERT_NOW(a_two_d_flat, out_vld_r && (DIMS < 3), near_z_r == '0, "z not zero in 2D")

endmodule
